// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising clock edge, off while reset is held
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, (cond) |-> (expr), msg)

`endif

// File: rtl/jsu_pkg.sv
// types and constants of the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEEK = 3'd1,
        PH_BODY = 3'd2,
        PH_ESC  = 3'd3,
        PH_HEX  = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        ST_BUSY   = 4'd0,
        ST_DONE   = 4'd1,
        ST_EXPSTR = 4'd2,
        ST_CTRL   = 4'd3,
        ST_BADESC = 4'd4,
        ST_BADHEX = 4'd5,
        ST_SURR   = 4'd6,
        ST_UNTERM = 4'd7,
        ST_SHORT  = 4'd8
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hex_digits_seen;
        logic [15:0] code_accumulator;
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_count;
        logic [7:0] out_byte_first;
        logic [7:0] out_byte_second;
        logic [7:0] out_byte_third;
        t_status    status;
    } t_out_item;

endpackage

// File: rtl/jsu_stream_if.sv
// valid/ready stream interface carrying one transaction payload
`timescale 1ns / 1ps

interface jsu_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/jsu_decode.sv
// per-byte decode: next state and result of one input byte
`timescale 1ns / 1ps

module jsu_decode
    import jsu_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        // bit 4 flags a valid digit
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    always_comb begin
        t_state     s;
        logic [7:0] c;
        logic       last;
        logic [4:0] hd;
        logic [15:0] cp;
        t_status    st;
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;

        s    = i_state;
        c    = i_item.data_byte;
        last = i_item.end_of_input;
        hd   = hex_digit(c);
        cp   = {s.code_accumulator[11:0], hd[3:0]};
        st   = ST_BUSY;
        n    = 2'd0;
        b0   = 8'd0;
        b1   = 8'd0;
        b2   = 8'd0;

        if (i_item.start_new) begin
            s = '{phase: PH_SEEK, hex_digits_seen: 2'd0, code_accumulator: 16'd0};
            cp = {12'd0, hd[3:0]};
        end

        unique case (s.phase)
            PH_SEEK: begin
                if (c == 8'h22) begin
                    s.phase = PH_BODY;
                    if (last) st = ST_UNTERM;
                end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
                    if (last) st = ST_EXPSTR;
                end else begin
                    st = ST_EXPSTR;
                end
            end
            PH_BODY: begin
                priority if (c == 8'h22) begin
                    st = ST_DONE;
                end else if (c < 8'h20) begin
                    st = ST_CTRL;
                end else if (c == 8'h5c) begin
                    s.phase = PH_ESC;
                    if (last) st = ST_UNTERM;
                end else begin
                    b0 = c;
                    n  = 2'd1;
                    if (last) st = ST_UNTERM;
                end
            end
            PH_ESC: begin
                if (c == 8'h75) begin
                    s.phase            = PH_HEX;
                    s.hex_digits_seen  = 2'd0;
                    s.code_accumulator = 16'd0;
                    if (last) st = ST_SHORT;
                end else begin
                    n = 2'd1;
                    unique case (c)
                        8'h22:   b0 = 8'h22;
                        8'h5c:   b0 = 8'h5c;
                        8'h2f:   b0 = 8'h2f;
                        8'h62:   b0 = 8'h08;
                        8'h66:   b0 = 8'h0c;
                        8'h6e:   b0 = 8'h0a;
                        8'h72:   b0 = 8'h0d;
                        8'h74:   b0 = 8'h09;
                        default: begin
                            n  = 2'd0;
                            st = ST_BADESC;
                        end
                    endcase
                    if (st == ST_BUSY) begin
                        s.phase = PH_BODY;
                        if (last) st = ST_UNTERM;
                    end
                end
            end
            PH_HEX: begin
                if (!hd[4]) begin
                    st = ST_BADHEX;
                end else if (s.hex_digits_seen == 2'd3) begin
                    s.hex_digits_seen  = 2'd0;
                    s.code_accumulator = 16'd0;
                    if (cp >= 16'hd800 && cp <= 16'hdfff) begin
                        st = ST_SURR;
                    end else begin
                        // utf-8 encode of a basic plane code point
                        priority if (cp <= 16'h007f) begin
                            n  = 2'd1;
                            b0 = cp[7:0];
                        end else if (cp <= 16'h07ff) begin
                            n  = 2'd2;
                            b0 = {3'b110, cp[10:6]};
                            b1 = {2'b10, cp[5:0]};
                        end else begin
                            n  = 2'd3;
                            b0 = {4'b1110, cp[15:12]};
                            b1 = {2'b10, cp[11:6]};
                            b2 = {2'b10, cp[5:0]};
                        end
                        s.phase = PH_BODY;
                        if (last) st = ST_UNTERM;
                    end
                end else begin
                    s.code_accumulator = cp;
                    s.hex_digits_seen  = s.hex_digits_seen + 2'd1;
                    if (last) st = ST_SHORT;
                end
            end
            default: begin
                s.phase = PH_IDLE;
            end
        endcase

        if (st != ST_BUSY) begin
            s = '{phase: PH_IDLE, hex_digits_seen: 2'd0, code_accumulator: 16'd0};
        end

        o_state  = s;
        o_result = '{out_count: n, out_byte_first: b0, out_byte_second: b1,
                     out_byte_third: b2, status: st};
    end

endmodule

// File: rtl/json_string_unescape.sv
// top level of the json string unescaper
`timescale 1ns / 1ps
`include "assert_macros.svh"

// json string unescaper. takes the raw bytes of one json string token, one byte per
// input transaction, and gives exactly one result transaction per byte: up to three
// decoded bytes (out_count says how many) and a status. a byte with start_new set makes
// the block seek an opening quote from that byte on; leading whitespace is skipped.
// body bytes pass through, the simple escapes map to single bytes and \uXXXX becomes
// one to three utf-8 bytes. after the closing quote (status done) or any error the block
// ignores bytes, answering count 0 and status busy, until the next start_new. error
// results never carry decoded bytes; unterminated input still delivers what the last
// byte decoded. throughput is one byte per clock while the skid register is empty: all
// decoding is a short combinational step from the held state and the input byte, and
// the state updates on the same edge that registers the result. the output side is a
// result register backed by one skid register; an accepted result goes to the skid
// register when the result register is occupied, and the input then holds ready low
// until the skid drains. no clearing pass after reset: the block is ready at once.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    jsu_stream_if.sink   i_in,
    jsu_stream_if.source o_out
);

    // decoder state and two-deep result buffer
    t_state    r_state;
    t_state    n_state;
    t_out_item w_res;
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;

    logic      in_fire;
    logic      out_fire;
    logic      load_out;

    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_out.ready;
    // result register free this cycle
    assign load_out    = !r_out_valid || out_fire;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    jsu_decode u_decode (
        .i_state  (r_state),
        .i_item   (i_in.data),
        .o_state  (n_state),
        .o_result (w_res)
    );

    // state advances only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, hex_digits_seen: 2'd0, code_accumulator: 16'd0};
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // control of the result register and the skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_fire;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (in_fire) r_skid <= w_res;
            end else if (in_fire) begin
                r_out <= w_res;
            end
        end else if (in_fire) begin
            r_skid <= w_res;
        end
    end

    // the skid register only fills behind an occupied result register
    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid register holds a transaction while result register is empty")

    // a final status always sends the decoder back to idle
    `ASSERT_CLK(a_final_to_idle, i_clk, i_rst_n,
        (in_fire && w_res.status != ST_BUSY) |=> (r_state.phase == PH_IDLE),
        "decoder not idle after a final status")

    // error results carry no decoded bytes
    `ASSERT_IMPL(a_error_no_bytes, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_BUSY && r_out.status != ST_DONE
            && r_out.status != ST_UNTERM,
        r_out.out_count == 2'd0,
        "error result carries decoded bytes")

endmodule

// File: tb/tb_json_string_unescape.sv
// self-checking testbench for the json string unescaper
`timescale 1ns / 1ps

module tb_json_string_unescape
    import jsu_pkg::*;
();

    localparam int    IDLE_LIMIT  = 1000;  // cycles with no transaction before giving up
    localparam int    ITEM_TARGET = 1450;
    localparam int    CALM_FROM   = 1300;  // no idling on either side after this many bytes
    localparam int    DRAIN_WAIT  = 20;
    localparam byte unsigned QUOTE    = 8'h22;
    localparam byte unsigned BSLASH   = 8'h5C;
    localparam byte unsigned LETTER_U = 8'h75;

    typedef struct {
        t_in_item item;
        bit       hold;   // sender waits for every decode before this byte
        bit       calm;   // tail of the run, no idling
    } t_pending;

    logic clk;
    logic rst_n;

    jsu_stream_if #(.T(t_in_item))  in_if ();
    jsu_stream_if #(.T(t_out_item)) out_if ();

    json_string_unescape dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_pending  byte_q[$];     // raw bytes still to be sent
    t_in_item  tok_q[$];      // token under construction
    t_out_item decoded_q[$];  // predicted decodes, oldest first
    int        errors = 0;
    int        n_items = 0;
    int        gap = 0;
    int        stall = 0;
    int        quiet = 0;
    bit        steady = 0;

    // shadow decoder state
    t_phase      m_phase = PH_IDLE;
    logic [1:0]  m_hex_cnt = '0;
    logic [15:0] m_code = '0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // {valid, mapped byte} of a simple escape letter
    function automatic logic [8:0] escape_code(input logic [7:0] c);
        case (c)
            8'h22:   return {1'b1, 8'h22};
            8'h5C:   return {1'b1, 8'h5C};
            8'h2F:   return {1'b1, 8'h2F};
            8'h62:   return {1'b1, 8'h08};
            8'h66:   return {1'b1, 8'h0C};
            8'h6E:   return {1'b1, 8'h0A};
            8'h72:   return {1'b1, 8'h0D};
            8'h74:   return {1'b1, 8'h09};
            default: return 9'h000;
        endcase
    endfunction

    // {valid, nibble} of a hex digit in either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'h00;
    endfunction

    // decodes one raw byte and advances the shadow state
    function automatic t_out_item unescape_byte(input t_in_item it);
        t_out_item   r;
        logic [7:0]  c;
        logic [8:0]  esc;
        logic [4:0]  hx;
        logic [15:0] cp;
        r = '0;
        r.status = ST_BUSY;
        c = it.data_byte;
        if (it.start_new) begin
            m_phase = PH_SEEK;
            m_hex_cnt = '0;
            m_code = '0;
        end
        case (m_phase)
            PH_SEEK: begin
                if (c == QUOTE) begin
                    m_phase = PH_BODY;
                    if (it.end_of_input) r.status = ST_UNTERM;
                end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
                    if (it.end_of_input) r.status = ST_EXPSTR;
                end else begin
                    r.status = ST_EXPSTR;
                end
            end
            PH_BODY: begin
                if (c == QUOTE) begin
                    r.status = ST_DONE;
                end else if (c < 8'h20) begin
                    r.status = ST_CTRL;
                end else if (c == BSLASH) begin
                    m_phase = PH_ESC;
                    if (it.end_of_input) r.status = ST_UNTERM;
                end else begin
                    r.out_count = 2'd1;
                    r.out_byte_first = c;
                    if (it.end_of_input) r.status = ST_UNTERM;
                end
            end
            PH_ESC: begin
                if (c == LETTER_U) begin
                    m_phase = PH_HEX;
                    m_hex_cnt = '0;
                    m_code = '0;
                    if (it.end_of_input) r.status = ST_SHORT;
                end else begin
                    esc = escape_code(c);
                    if (!esc[8]) begin
                        r.status = ST_BADESC;
                    end else begin
                        r.out_count = 2'd1;
                        r.out_byte_first = esc[7:0];
                        m_phase = PH_BODY;
                        if (it.end_of_input) r.status = ST_UNTERM;
                    end
                end
            end
            PH_HEX: begin
                hx = hex_digit(c);
                if (!hx[4]) begin
                    r.status = ST_BADHEX;
                end else begin
                    cp = {m_code[11:0], hx[3:0]};
                    if (m_hex_cnt == 2'd3) begin
                        m_hex_cnt = '0;
                        m_code = '0;
                        if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
                            r.status = ST_SURR;
                        end else begin
                            // utf-8 in one, two or three bytes
                            if (cp <= 16'h007F) begin
                                r.out_count = 2'd1;
                                r.out_byte_first = cp[7:0];
                            end else if (cp <= 16'h07FF) begin
                                r.out_count = 2'd2;
                                r.out_byte_first = 8'hC0 | {3'b000, cp[10:6]};
                                r.out_byte_second = 8'h80 | {2'b00, cp[5:0]};
                            end else begin
                                r.out_count = 2'd3;
                                r.out_byte_first = 8'hE0 | {4'h0, cp[15:12]};
                                r.out_byte_second = 8'h80 | {2'b00, cp[11:6]};
                                r.out_byte_third = 8'h80 | {2'b00, cp[5:0]};
                            end
                            m_phase = PH_BODY;
                            if (it.end_of_input) r.status = ST_UNTERM;
                        end
                    end else begin
                        m_code = cp;
                        m_hex_cnt = m_hex_cnt + 2'd1;
                        if (it.end_of_input) r.status = ST_SHORT;
                    end
                end
            end
            default: m_phase = PH_IDLE;
        endcase
        // done or any error drops back to idle
        if (r.status != ST_BUSY) begin
            m_phase = PH_IDLE;
            m_hex_cnt = '0;
            m_code = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want_v, got_v);
        end
    endfunction

    // ---------------------------------------------------------------- token building

    task automatic add_raw(input logic [7:0] b, input bit s, input bit l);
        t_in_item t;
        t.data_byte = b;
        t.start_new = s;
        t.end_of_input = l;
        tok_q = {tok_q, t};
    endtask

    // first byte of a token carries start_new
    task automatic put(input logic [7:0] b);
        add_raw(b, tok_q.size() == 0, 1'b0);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic mark_last();
        tok_q[tok_q.size() - 1].end_of_input = 1'b1;
    endtask

    // \u followed by the first k digits of cp, letters in random case
    task automatic put_hex(input logic [15:0] cp, input int k);
        logic [3:0] nib;
        put(BSLASH);
        put(LETTER_U);
        for (int i = 0; i < k; i++) begin
            nib = cp[15 - 4 * i -: 4];
            if (nib < 4'd10) put(8'h30 + nib);
            else put(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
        end
    endtask

    task automatic put_element();
        logic [7:0]  c;
        logic [15:0] cp;
        byte unsigned esc_chars[8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == QUOTE || c == BSLASH);
                put(c);
            end
            5, 6: begin
                put(BSLASH);
                put(esc_chars[$urandom_range(0, 7)]);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hD7FF));
                    default: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
                endcase
                put_hex(cp, 4);
            end
        endcase
    endtask

    task automatic put_error();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: put(8'($urandom_range(8'h00, 8'h1F)));
            1: begin
                put(BSLASH);
                do c = 8'($urandom_range(0, 255));
                while (escape_code(c) != 9'h000 || c == LETTER_U);
                put(c);
            end
            2: begin
                put_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
                do c = 8'($urandom_range(0, 255)); while (hex_digit(c) != 5'h00);
                put(c);
            end
            default: put_hex(16'($urandom_range(16'hD800, 16'hDFFF)), 4);
        endcase
    endtask

    task automatic emit(input bit calm, input bit hold);
        t_pending p;
        for (int i = 0; i < tok_q.size(); i++) begin
            p.item = tok_q[i];
            p.calm = calm;
            p.hold = hold && (i == 0);
            byte_q = {byte_q, p};
        end
        n_items += tok_q.size();
        tok_q.delete();
    endtask

    task automatic build_stimulus();
        int  kind;
        int  len;
        int  bad_at;
        int  cut;
        bit  held;
        bit  calm;
        byte unsigned ws_chars[6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        held = 1'b0;
        // directed: ignored while idle, whitespace then control char
        add_raw(8'hFF, 1'b0, 1'b0);
        emit(1'b0, 1'b0);
        put_text("\t \"A");
        put(8'h00);
        emit(1'b0, 1'b0);
        // two byte utf-8, mixed case hex, closing quote, byte after done is ignored
        put_text("\"\\u07fF\"z");
        emit(1'b0, 1'b0);
        // largest codepoint on the last byte gives bytes and unterminated
        put_text("\"\\uFFFF");
        mark_last();
        emit(1'b0, 1'b0);
        // bad escape, then non-quote while seeking, then input ending on whitespace
        put_text("\"\\q");
        emit(1'b0, 1'b0);
        put(BSLASH);
        emit(1'b0, 1'b0);
        put(8'h20);
        mark_last();
        emit(1'b0, 1'b0);

        // random tokens: mostly well formed, some broken, some noise
        while (n_items < ITEM_TARGET) begin
            calm = n_items >= CALM_FROM;
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 6))
                    add_raw(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 7) == 0);
            end else begin
                repeat ($urandom_range(0, 2)) put(ws_chars[$urandom_range(0, 5)]);
                put(QUOTE);
                len = $urandom_range(kind == 7 ? 1 : 0, 8);
                bad_at = (kind == 7) ? $urandom_range(0, len - 1) : -1;
                for (int i = 0; i < len; i++) begin
                    if (i == bad_at) put_error();
                    else put_element();
                end
                put(QUOTE);
                if ($urandom_range(0, 1)) mark_last();
                // truncated token: input ends somewhere inside
                if (kind == 8) begin
                    cut = $urandom_range(0, tok_q.size() - 1);
                    while (tok_q.size() > cut + 1) void'(tok_q.pop_back());
                    mark_last();
                end
                repeat ($urandom_range(0, 2))
                    add_raw(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
            end
            emit(calm, !held && n_items > ITEM_TARGET / 2);
            if (n_items > ITEM_TARGET / 2) held = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin
        t_pending nx;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            gap         <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decoded_q = {decoded_q, unescape_byte(in_if.data)};
            end
            // only change the offer once the current transaction has gone
            if (!in_if.valid || in_if.ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    in_if.valid <= 1'b0;
                end else if (byte_q.size() == 0) begin
                    in_if.valid <= 1'b0;
                end else if (byte_q[0].hold && decoded_q.size() != 0) begin
                    // hold off until every decode has come back
                    in_if.valid <= 1'b0;
                end else if (!byte_q[0].calm && $urandom_range(0, 7) == 0) begin
                    gap <= $urandom_range(0, 8);
                    in_if.valid <= 1'b0;
                end else begin
                    nx = byte_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data  <= nx.item;
                    steady      <= nx.calm;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall        <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual %p",
                             $time, out_if.data);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_count", 8'(want.out_count),
                                8'(out_if.data.out_count));
                    check_field("out_byte_first", want.out_byte_first,
                                out_if.data.out_byte_first);
                    check_field("out_byte_second", want.out_byte_second,
                                out_if.data.out_byte_second);
                    check_field("out_byte_third", want.out_byte_third,
                                out_if.data.out_byte_third);
                    check_field("status", 8'(want.status), 8'(out_if.data.status));
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                out_if.ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                stall <= $urandom_range(0, 8);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk);
        while (byte_q.size() != 0 || in_if.valid || decoded_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
